// ----- src/pgp_pkg.sv -----
// ----------------------------------------------------------------------------
// pgp_pkg
// Shared types and codes for the OpenPGP packet deframer: event and error
// codes and the per-word result record.
// ----------------------------------------------------------------------------
package pgp_pkg;

	typedef enum logic [2:0] {
		EV_FRAMING = 3'd0,
		EV_PAYLOAD = 3'd1,
		EV_EMPTY   = 3'd2,
		EV_ERROR   = 3'd3,
		EV_IGNORED = 3'd4
	} pgp_event_t;

	typedef enum logic [2:0] {
		ERR_BAD_HEADER  = 3'd0,
		ERR_PARTIAL_LEN = 3'd1,
		ERR_TRUNC_LEN   = 3'd2,
		ERR_TRUNC_BODY  = 3'd3,
		ERR_ZERO_SUB    = 3'd4
	} pgp_err_t;

	typedef struct packed {
		pgp_event_t  event_res;
		logic [7:0]  payload_byte;
		logic [7:0]  pkt_tag;
		logic [31:0] body_length;
		logic        is_indeterminate;
		logic        first_of_packet;
		logic        last_of_packet;
		pgp_err_t    error_code;
	} pgp_result_t;

	localparam int unsigned TDATA_W = 56;
	localparam int unsigned TUSER_W = 2;

endpackage

// ----- src/pgp_core.sv -----
// ----------------------------------------------------------------------------
// pgp_core
// Header and length state machine. Consumes one octet per step and returns
// the event for that octet; all parsing state lives here.
// ----------------------------------------------------------------------------
module pgp_core
	import pgp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  logic [7:0]  in_byte,
	input  logic        end_of_data,
	input  logic        stream_mode,
	output pgp_result_t res
);

	typedef enum logic [2:0] {
		PH_HDR    = 3'd0,
		PH_NEWLEN = 3'd1,
		PH_TWO    = 3'd2,
		PH_MULTI  = 3'd3,
		PH_TAG    = 3'd4,
		PH_BODY   = 3'd5,
		PH_INDET  = 3'd6,
		PH_ERR    = 3'd7
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  tag_q, tag_n;
	logic [31:0] acc_q, acc_n;
	logic [2:0]  lbl_q, lbl_n;
	logic [31:0] body_q, body_n;
	logic        ind_q, ind_n;
	logic        first_q, first_n;
	pgp_err_t    errc_q, errc_n;

	always_comb begin
		logic        sub;
		logic        do_first;
		logic        do_finish;
		logic        raise;
		pgp_err_t    raise_code;
		logic [31:0] fin_len;
		logic [31:0] acc_shift;
		logic [31:0] acc_dec;
		logic [31:0] body_dec;
		logic [2:0]  lbl_dec;
		pgp_event_t  ev;
		logic [7:0]  pay;
		logic        fst;
		logic        lst;
		pgp_err_t    ec;

		sub        = stream_mode;
		do_first   = 1'b0;
		do_finish  = 1'b0;
		raise      = 1'b0;
		raise_code = ERR_BAD_HEADER;
		fin_len    = '0;
		acc_shift  = {acc_q[23:0], in_byte};
		acc_dec    = acc_q - 32'd1;
		body_dec   = (body_q != '0) ? body_q - 32'd1 : body_q;
		lbl_dec    = (lbl_q != '0) ? lbl_q - 3'd1 : lbl_q;
		ev         = EV_FRAMING;
		pay        = '0;
		fst        = 1'b0;
		lst        = 1'b0;
		ec         = ERR_BAD_HEADER;

		phase_n = phase_q;
		tag_n   = tag_q;
		acc_n   = acc_q;
		lbl_n   = lbl_q;
		body_n  = body_q;
		ind_n   = ind_q;
		first_n = first_q;
		errc_n  = errc_q;

		case (phase_q)
			PH_HDR: begin
				tag_n = '0;
				acc_n = '0;
				ind_n = 1'b0;
				if (sub) begin
					do_first = 1'b1;
				end else if (end_of_data) begin
					ev = EV_IGNORED;
				end else if (!in_byte[7]) begin
					raise      = 1'b1;
					raise_code = ERR_BAD_HEADER;
				end else if (!in_byte[6]) begin
					tag_n = {4'd0, in_byte[5:2]};
					if (in_byte[1:0] == 2'd3) begin
						ind_n   = 1'b1;
						first_n = 1'b1;
						phase_n = PH_INDET;
					end else begin
						// Old-format length of 1, 2 or 4 octets.
						lbl_n   = 3'd1 << in_byte[1:0];
						phase_n = PH_MULTI;
					end
				end else begin
					tag_n   = {2'd0, in_byte[5:0]};
					phase_n = PH_NEWLEN;
				end
			end
			PH_NEWLEN: begin
				do_first = 1'b1;
			end
			PH_TWO: begin
				do_finish = 1'b1;
				fin_len   = {acc_q[23:0], 8'd0} + {24'd0, in_byte} + 32'd192;
			end
			PH_MULTI: begin
				acc_n = acc_shift;
				lbl_n = lbl_dec;
				if (lbl_dec == '0) begin
					do_finish = 1'b1;
					fin_len   = acc_shift;
				end else if (end_of_data) begin
					raise      = 1'b1;
					raise_code = ERR_TRUNC_LEN;
				end
			end
			PH_TAG: begin
				tag_n = in_byte;
				acc_n = acc_dec;
				if (acc_dec == '0) begin
					ev      = EV_EMPTY;
					lst     = 1'b1;
					phase_n = PH_HDR;
				end else if (end_of_data) begin
					raise      = 1'b1;
					raise_code = ERR_TRUNC_BODY;
				end else begin
					body_n  = acc_dec;
					first_n = 1'b1;
					phase_n = PH_BODY;
				end
			end
			PH_BODY: begin
				if (body_q > 32'd1 && end_of_data) begin
					raise      = 1'b1;
					raise_code = ERR_TRUNC_BODY;
				end else begin
					ev      = EV_PAYLOAD;
					pay     = in_byte;
					fst     = first_q;
					first_n = 1'b0;
					body_n  = body_dec;
					if (body_dec == '0) begin
						lst     = 1'b1;
						phase_n = PH_HDR;
					end
				end
			end
			PH_INDET: begin
				ev      = EV_PAYLOAD;
				pay     = in_byte;
				fst     = first_q;
				first_n = 1'b0;
				lst     = end_of_data;
			end
			default: begin
				ev = EV_ERROR;
				ec = errc_q;
			end
		endcase

		// First length octet; subpackets take every value from 192 to 254 as two-octet.
		if (do_first) begin
			acc_n = '0;
			if (in_byte < 8'd192) begin
				do_finish = 1'b1;
				fin_len   = {24'd0, in_byte};
			end else if (in_byte < 8'd224 || (sub && in_byte != 8'd255)) begin
				if (end_of_data) begin
					raise      = 1'b1;
					raise_code = ERR_TRUNC_LEN;
				end else begin
					acc_n   = {24'd0, in_byte - 8'd192};
					phase_n = PH_TWO;
				end
			end else if (in_byte != 8'd255) begin
				raise      = 1'b1;
				raise_code = ERR_PARTIAL_LEN;
			end else if (end_of_data) begin
				raise      = 1'b1;
				raise_code = ERR_TRUNC_LEN;
			end else begin
				lbl_n   = 3'd4;
				phase_n = PH_MULTI;
			end
		end

		if (do_finish) begin
			acc_n = fin_len;
			if (sub) begin
				if (fin_len == '0) begin
					raise      = 1'b1;
					raise_code = ERR_ZERO_SUB;
				end else if (end_of_data) begin
					raise      = 1'b1;
					raise_code = ERR_TRUNC_BODY;
				end else begin
					phase_n = PH_TAG;
				end
			end else if (fin_len == '0) begin
				ev      = EV_EMPTY;
				lst     = 1'b1;
				phase_n = PH_HDR;
			end else if (end_of_data) begin
				raise      = 1'b1;
				raise_code = ERR_TRUNC_BODY;
			end else begin
				body_n  = fin_len;
				first_n = 1'b1;
				phase_n = PH_BODY;
			end
		end

		if (raise) begin
			ev      = EV_ERROR;
			ec      = raise_code;
			errc_n  = raise_code;
			phase_n = PH_ERR;
		end

		res.event_res        = ev;
		res.payload_byte     = pay;
		res.first_of_packet  = fst;
		res.last_of_packet   = lst;
		res.error_code       = (ev == EV_ERROR) ? ec : ERR_BAD_HEADER;
		res.pkt_tag          = (ev <= EV_EMPTY) ? tag_n : '0;
		res.is_indeterminate = (ev <= EV_EMPTY) ? ind_n : 1'b0;
		res.body_length      = (ev <= EV_EMPTY && !ind_n) ? acc_n : '0;

		// The end of the stream returns every parsing register to its reset value.
		if (end_of_data) begin
			phase_n = PH_HDR;
			tag_n   = '0;
			acc_n   = '0;
			lbl_n   = '0;
			body_n  = '0;
			ind_n   = 1'b0;
			first_n = 1'b0;
			errc_n  = ERR_BAD_HEADER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			tag_q   <= '0;
			acc_q   <= '0;
			lbl_q   <= '0;
			body_q  <= '0;
			ind_q   <= 1'b0;
			first_q <= 1'b0;
			errc_q  <= ERR_BAD_HEADER;
		end else if (step_en) begin
			phase_q <= phase_n;
			tag_q   <= tag_n;
			acc_q   <= acc_n;
			lbl_q   <= lbl_n;
			body_q  <= body_n;
			ind_q   <= ind_n;
			first_q <= first_n;
			errc_q  <= errc_n;
		end
	end

	// Once in the error phase, every word reports the latched error.
	a_sticky_error: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && phase_q == PH_ERR |-> res.event_res == EV_ERROR && res.error_code == errc_q)
		else $error("error phase did not report the latched error");

	// A word that ends the stream leaves the parser waiting for a new packet.
	a_eod_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && end_of_data |=> phase_q == PH_HDR && body_q == '0 && !first_q)
		else $error("end of stream did not clear the parser");

	// Multi-octet length collection always has octets left to take.
	a_multi_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MULTI |-> lbl_q != '0 && lbl_q <= 3'd4)
		else $error("length octet count out of range");

endmodule

// ----- src/pgp_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// pgp_packet_deframer
// Splits an OpenPGP octet stream (packet or signature subpacket form) into
// framing, payload, empty-packet and error events, one event per octet.
// ----------------------------------------------------------------------------
//  channel   direction  fields
//  s_*       in         tdata[7:0] in_byte, tlast end_of_data
//  m_*       out        tdata event/payload/tag/length/error, tuser indet/first,
//                       tlast last_of_packet
//  cfg_*     in         cfg_wdata stream_mode, written when cfg_we is high
//
// One word per cycle while m_tready is high; each word passes through the input
// register and then the result register. The parsing state machine updates in
// the cycle a word leaves the input register. Reset clears the valid flags and
// all parsing state and selects packet mode. A stall on m_tready holds the
// result register and backs up into the input register.
// ----------------------------------------------------------------------------
module pgp_packet_deframer
	import pgp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] in_byte
	input  logic               s_tlast,   // end_of_data
	output logic               m_tvalid,
	input  logic               m_tready,
	// [2:0] event_res, [10:3] payload_byte, [18:11] pkt_tag,
	// [50:19] body_length, [53:51] error_code, [55:54] zero
	output logic [TDATA_W-1:0] m_tdata,
	output logic [TUSER_W-1:0] m_tuser,   // [0] is_indeterminate, [1] first_of_packet
	output logic               m_tlast,   // last_of_packet
	input  logic               cfg_we,
	input  logic               cfg_wdata  // stream_mode
);

	logic        mode_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eod_s1;
	logic        adv;
	pgp_result_t res;
	logic        valid_s2;
	pgp_result_t res_s2;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eod_s1  <= s_tlast;
		end
	end

	pgp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (adv),
		.in_byte     (byte_s1),
		.end_of_data (eod_s1),
		.stream_mode (mode_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.error_code, res_s2.body_length, res_s2.pkt_tag,
		res_s2.payload_byte, res_s2.event_res};
	assign m_tuser  = {res_s2.first_of_packet, res_s2.is_indeterminate};
	assign m_tlast  = res_s2.last_of_packet;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pgp_packet_deframer. A queue of octets, built from
// a few directed streams and many random packet and subpacket streams, feeds
// a clocked driver. Each accepted word is decoded by a local parser model,
// and the monitor compares every result word with the oldest prediction.
// Both sides idle at random, and the receiver stalls once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
	import pgp_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT  = 2000;
	localparam int unsigned HOLD_CYCLES     = 120;
	localparam int unsigned RANDOM_ITEMS    = 520;
	localparam int unsigned PRESSURE_MIN    = 16;
	localparam int          PRESSURE_PHASE  = 4;
	localparam int          LAST_PHASE      = 12;
	localparam logic        MODE_PACKET     = 1'b0;
	localparam logic        MODE_SUBPACKET  = 1'b1;

	typedef enum logic [2:0] {
		ST_HEADER, ST_NEW_LEN, ST_TWO_OCTET, ST_MULTI_LEN,
		ST_SUB_TAG, ST_BODY, ST_INDET, ST_ERROR
	} parse_phase_t;

	typedef struct {
		logic [7:0]  octet;
		logic        last;
		int unsigned gap;
	} octet_item_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = 8'd0;   // [7:0] in_byte
	logic               s_tlast = 1'b0;   // end_of_data
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	// [2:0] event_res, [10:3] payload_byte, [18:11] pkt_tag,
	// [50:19] body_length, [53:51] error_code
	logic [TDATA_W-1:0] m_tdata;
	logic [TUSER_W-1:0] m_tuser;          // [0] is_indeterminate, [1] first_of_packet
	logic               m_tlast;          // last_of_packet
	logic               cfg_we;
	logic               cfg_wdata;

	pgp_packet_deframer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Parser model state and the outputs of the octet being decoded.
	parse_phase_t ps_phase;
	logic [7:0]   ps_tag;
	logic [31:0]  ps_len;
	logic [2:0]   ps_len_left;
	logic [31:0]  ps_body_left;
	logic         ps_indet;
	logic         ps_first_pend;
	pgp_err_t     ps_err;
	logic         cur_mode;
	pgp_event_t   ev_out;
	logic [7:0]   pay_out;
	logic         fst_out;
	logic         lst_out;
	pgp_err_t     code_out;

	octet_item_t  pending_q[$];
	pgp_result_t  result_q[$];
	logic [7:0]   octet_buf[$];
	octet_item_t  tx_next;
	pgp_result_t  rx_want;
	int unsigned  words_accepted = 0;
	int unsigned  total_queued = 0;
	int unsigned  fail_count = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  tx_waited = 0;
	int unsigned  rx_wait = 0;
	int unsigned  tx_max_gap = 0;
	int unsigned  rx_max_gap = 0;
	int           phase_no = 0;
	logic         hold_done = 1'b0;

	function automatic void clear_parse();
		ps_phase      = ST_HEADER;
		ps_tag        = 8'd0;
		ps_len        = 32'd0;
		ps_len_left   = 3'd0;
		ps_body_left  = 32'd0;
		ps_indet      = 1'b0;
		ps_first_pend = 1'b0;
		ps_err        = ERR_BAD_HEADER;
	endfunction

	function automatic void flag_error(input pgp_err_t code);
		ev_out   = EV_ERROR;
		code_out = code;
		ps_err   = code;
		ps_phase = ST_ERROR;
	endfunction

	function automatic void close_length(input logic [31:0] len, input logic eod,
			input logic sub);
		ps_len = len;
		if (sub) begin
			if (len == 32'd0)
				flag_error(ERR_ZERO_SUB);
			else if (eod)
				flag_error(ERR_TRUNC_BODY);
			else
				ps_phase = ST_SUB_TAG;
		end else if (len == 32'd0) begin
			ev_out   = EV_EMPTY;
			lst_out  = 1'b1;
			ps_phase = ST_HEADER;
		end else if (eod) begin
			flag_error(ERR_TRUNC_BODY);
		end else begin
			ps_body_left  = len;
			ps_first_pend = 1'b1;
			ps_phase      = ST_BODY;
		end
	endfunction

	function automatic void open_length(input logic [7:0] b, input logic eod,
			input logic sub);
		ps_len = 32'd0;
		if (b < 8'd192) begin
			close_length(32'(b), eod, sub);
		end else if (b < 8'd224 || (sub && b < 8'd255)) begin
			if (eod) begin
				flag_error(ERR_TRUNC_LEN);
			end else begin
				ps_len   = 32'(b) - 32'd192;
				ps_phase = ST_TWO_OCTET;
			end
		end else if (b < 8'd255) begin
			flag_error(ERR_PARTIAL_LEN);
		end else if (eod) begin
			flag_error(ERR_TRUNC_LEN);
		end else begin
			ps_len_left = 3'd4;
			ps_phase    = ST_MULTI_LEN;
		end
	endfunction

	// Decodes one octet, advances the parser and returns the result word.
	function automatic pgp_result_t decode_octet(input logic [7:0] b, input logic eod);
		pgp_result_t r;
		logic        sub;
		logic        live;
		sub      = cur_mode;
		ev_out   = EV_FRAMING;
		pay_out  = 8'd0;
		fst_out  = 1'b0;
		lst_out  = 1'b0;
		code_out = ERR_BAD_HEADER;
		case (ps_phase)
			ST_HEADER: begin
				ps_tag   = 8'd0;
				ps_len   = 32'd0;
				ps_indet = 1'b0;
				if (sub) begin
					open_length(b, eod, 1'b1);
				end else if (eod) begin
					ev_out = EV_IGNORED;
				end else if (!b[7]) begin
					flag_error(ERR_BAD_HEADER);
				end else if (!b[6]) begin
					ps_tag = {4'd0, b[5:2]};
					if (b[1:0] == 2'd3) begin
						ps_indet      = 1'b1;
						ps_first_pend = 1'b1;
						ps_phase      = ST_INDET;
					end else begin
						ps_len_left = 3'd1 << b[1:0];
						ps_phase    = ST_MULTI_LEN;
					end
				end else begin
					ps_tag   = {2'd0, b[5:0]};
					ps_phase = ST_NEW_LEN;
				end
			end
			ST_NEW_LEN: open_length(b, eod, sub);
			ST_TWO_OCTET: close_length((ps_len << 8) + 32'(b) + 32'd192, eod, sub);
			ST_MULTI_LEN: begin
				ps_len = (ps_len << 8) | 32'(b);
				if (ps_len_left != 3'd0)
					ps_len_left = ps_len_left - 3'd1;
				if (ps_len_left == 3'd0)
					close_length(ps_len, eod, sub);
				else if (eod)
					flag_error(ERR_TRUNC_LEN);
			end
			ST_SUB_TAG: begin
				// The tag octet is counted in the subpacket length.
				ps_tag = b;
				ps_len = ps_len - 32'd1;
				if (ps_len == 32'd0) begin
					ev_out   = EV_EMPTY;
					lst_out  = 1'b1;
					ps_phase = ST_HEADER;
				end else if (eod) begin
					flag_error(ERR_TRUNC_BODY);
				end else begin
					ps_body_left  = ps_len;
					ps_first_pend = 1'b1;
					ps_phase      = ST_BODY;
				end
			end
			ST_BODY: begin
				if (ps_body_left > 32'd1 && eod) begin
					flag_error(ERR_TRUNC_BODY);
				end else begin
					ev_out        = EV_PAYLOAD;
					pay_out       = b;
					fst_out       = ps_first_pend;
					ps_first_pend = 1'b0;
					if (ps_body_left != 32'd0)
						ps_body_left = ps_body_left - 32'd1;
					if (ps_body_left == 32'd0) begin
						lst_out  = 1'b1;
						ps_phase = ST_HEADER;
					end
				end
			end
			ST_INDET: begin
				ev_out        = EV_PAYLOAD;
				pay_out       = b;
				fst_out       = ps_first_pend;
				ps_first_pend = 1'b0;
				lst_out       = eod;
			end
			default: begin
				ev_out   = EV_ERROR;
				code_out = ps_err;
			end
		endcase
		live = (ev_out == EV_FRAMING || ev_out == EV_PAYLOAD || ev_out == EV_EMPTY);
		r.event_res        = ev_out;
		r.payload_byte     = (ev_out == EV_PAYLOAD) ? pay_out : 8'd0;
		r.pkt_tag          = live ? ps_tag : 8'd0;
		r.body_length      = (live && !ps_indet) ? ps_len : 32'd0;
		r.is_indeterminate = live & ps_indet;
		r.first_of_packet  = fst_out;
		r.last_of_packet   = lst_out;
		r.error_code       = (ev_out == EV_ERROR) ? code_out : ERR_BAD_HEADER;
		if (eod)
			clear_parse();
		return r;
	endfunction

	function automatic void queue_octet(input logic [7:0] b, input logic last);
		octet_item_t it;
		it.octet = b;
		it.last  = last;
		it.gap   = $urandom_range(tx_max_gap, 0);
		pending_q.insert(pending_q.size(), it);
		total_queued++;
	endfunction

	function automatic void flush_buf(input logic terminate);
		int unsigned i;
		for (i = 0; i < octet_buf.size(); i++)
			queue_octet(octet_buf[i], terminate && (i == octet_buf.size() - 1));
	endfunction

	function automatic void append_octet(input logic [7:0] b);
		octet_buf.insert(octet_buf.size(), b);
	endfunction

	function automatic void push_word32(input logic [31:0] w);
		append_octet(w[31:24]);
		append_octet(w[23:16]);
		append_octet(w[15:8]);
		append_octet(w[7:0]);
	endfunction

	// Appends one packet or subpacket. Stop is set when the stream must end
	// here, for example after a length too large to send a body for.
	function automatic void add_packet(input logic sub, output logic stop);
		int unsigned pick;
		int unsigned len;
		int unsigned tail;
		int unsigned low;
		int unsigned i;
		logic [1:0]  lt;
		logic [31:0] wide;
		stop = 1'b0;
		pick = $urandom_range(9, 0);
		len  = $urandom_range(15, 0);
		tail = $urandom_range(6, 0);
		low  = $urandom_range(8, 0);
		wide = $urandom();
		if (sub) begin
			if (pick <= 5) begin
				len = $urandom_range(14, 1);
				append_octet(8'(len));
			end else if (pick == 6) begin
				append_octet(8'd192);
				append_octet(8'(low));
				len = 192 + low;
			end else if (pick == 7) begin
				len = $urandom_range(10, 1);
				append_octet(8'd255);
				push_word32(32'(len));
			end else if (pick == 8) begin
				append_octet(($urandom_range(1, 0) == 0) ? 8'd0 : 8'd255);
				if (octet_buf[octet_buf.size() - 1] == 8'd255)
					push_word32(32'd0);
				len  = 0;
				stop = 1'b1;
			end else begin
				if ($urandom_range(1, 0) == 0) begin
					append_octet(8'($urandom_range(254, 192)));
					append_octet(wide[7:0]);
				end else begin
					append_octet(8'd255);
					push_word32(wide);
				end
				len  = tail;
				stop = 1'b1;
			end
		end else if (pick <= 3) begin
			append_octet({2'b11, 6'($urandom_range(63, 0))});
			pick = $urandom_range(9, 0);
			if (pick <= 5) begin
				append_octet(8'(len));
			end else if (pick == 6) begin
				append_octet(8'd192);
				append_octet(8'(low));
				len = 192 + low;
			end else if (pick == 7) begin
				append_octet(8'd255);
				push_word32(32'(len));
			end else if (pick == 8) begin
				append_octet(8'($urandom_range(254, 224)));
				len  = tail;
				stop = 1'b1;
			end else begin
				pick = $urandom_range(2, 0);
				if (pick == 0) begin
					append_octet(8'(wide[7:0] % 192));
				end else if (pick == 1) begin
					append_octet(8'd192 + {3'd0, wide[12:8]});
					append_octet(wide[7:0]);
				end else begin
					append_octet(8'd255);
					push_word32(wide);
				end
				len  = tail;
				stop = 1'b1;
			end
		end else if (pick <= 6) begin
			lt = 2'($urandom_range(2, 0));
			append_octet({2'b10, 4'($urandom_range(15, 0)), lt});
			if ($urandom_range(7, 0) == 0) begin
				len  = tail;
				stop = 1'b1;
			end else begin
				wide = 32'(len);
			end
			for (i = (1 << lt); i > 0; i--)
				append_octet(wide[8*(i-1) +: 8]);
		end else if (pick == 7) begin
			// Indeterminate body: runs until the end of the stream.
			append_octet({2'b10, 4'($urandom_range(15, 0)), 2'b11});
			len  = $urandom_range(10, 0);
			stop = 1'b1;
		end else if (pick == 8) begin
			append_octet(8'($urandom_range(127, 0)));
			len  = $urandom_range(3, 0);
			stop = 1'b1;
		end else begin
			append_octet(8'($urandom_range(255, 0)));
			len  = 0;
			stop = 1'b1;
		end
		for (i = 0; i < len; i++)
			append_octet(8'($urandom_range(255, 0)));
	endfunction

	// A stream of a few packets, usually ended cleanly, sometimes with a
	// trailing octet, cut short or with one octet corrupted.
	function automatic void build_stream(input logic sub, input logic terminate);
		int unsigned i;
		int unsigned count;
		int unsigned ending;
		int unsigned keep;
		logic        stop;
		octet_buf.delete();
		stop  = 1'b0;
		count = $urandom_range(4, 1);
		for (i = 0; i < count && !stop; i++)
			add_packet(sub, stop);
		ending = $urandom_range(9, 0);
		if (ending == 7) begin
			append_octet(8'($urandom_range(255, 0)));
		end else if (ending == 8) begin
			keep = $urandom_range(octet_buf.size(), 1);
			while (octet_buf.size() > keep)
				octet_buf.delete(octet_buf.size() - 1);
		end else if (ending == 9) begin
			octet_buf[$urandom_range(octet_buf.size() - 1, 0)] = 8'($urandom_range(255, 0));
		end
		flush_buf(terminate);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic write_mode(input logic m);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		cur_mode  = m;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic wait_drained();
		while (words_accepted != total_queued || result_q.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// Driver: presents queued octets after each one's drawn gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			s_tdata   <= 8'd0;
			s_tlast   <= 1'b0;
			tx_waited = 0;
			clear_parse();
		end else begin
			if (s_tvalid && s_tready) begin
				result_q.insert(result_q.size(), decode_octet(s_tdata, s_tlast));
				words_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (tx_waited < pending_q[0].gap) begin
					s_tvalid <= 1'b0;
					tx_waited++;
				end else begin
					tx_next   = pending_q.pop_front();
					s_tvalid  <= 1'b1;
					s_tdata   <= tx_next.octet;
					s_tlast   <= tx_next.last;
					tx_waited = 0;
				end
			end
		end
	end

	// Monitor: checks each result word and draws the next receive gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			rx_wait   = 0;
			hold_done = 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$error("result word with nothing expected: tdata %h", m_tdata);
					fail_count++;
				end else begin
					rx_want = result_q.pop_front();
					check_field("event_res", 32'(rx_want.event_res), 32'(m_tdata[2:0]));
					check_field("payload_byte", 32'(rx_want.payload_byte),
						32'(m_tdata[10:3]));
					check_field("pkt_tag", 32'(rx_want.pkt_tag), 32'(m_tdata[18:11]));
					check_field("body_length", rx_want.body_length, m_tdata[50:19]);
					check_field("error_code", 32'(rx_want.error_code), 32'(m_tdata[53:51]));
					check_field("is_indeterminate", 32'(rx_want.is_indeterminate),
						32'(m_tuser[0]));
					check_field("first_of_packet", 32'(rx_want.first_of_packet),
						32'(m_tuser[1]));
					check_field("last_of_packet", 32'(rx_want.last_of_packet),
						32'(m_tlast));
				end
				rx_wait = $urandom_range(rx_max_gap, 0);
				// One long hold-off so the block backs up into its input.
				if (phase_no == PRESSURE_PHASE && !hold_done) begin
					rx_wait   = HOLD_CYCLES;
					hold_done = 1'b1;
				end
			end
			if (rx_wait > 0) begin
				m_tready <= 1'b0;
				rx_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		int unsigned start;
		int unsigned phase_start;
		logic        mode;
		cfg_we     = 1'b0;
		cfg_wdata  = 1'b0;
		cur_mode   = MODE_PACKET;
		tx_max_gap = 2;
		rx_max_gap = 2;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Packet mode at its reset value: lone last octet, bad header bit
		// with a sticky error, empty and short packets, partial length,
		// indeterminate body.
		@(negedge clk);
		octet_buf = '{8'h00};
		flush_buf(1'b1);
		octet_buf = '{8'h3C, 8'hA5};
		flush_buf(1'b1);
		octet_buf = '{8'hBC, 8'h00, 8'hFF, 8'h01, 8'h5A, 8'h85, 8'h00, 8'h02, 8'h00, 8'hFF};
		flush_buf(1'b1);
		octet_buf = '{8'hC2, 8'hE0, 8'h11};
		flush_buf(1'b1);
		octet_buf = '{8'h8F, 8'h00, 8'hFF};
		flush_buf(1'b1);
		wait_drained();

		// Subpacket mode: a length-one subpacket, a short one, a zero one.
		write_mode(MODE_SUBPACKET);
		@(negedge clk);
		octet_buf = '{8'h01, 8'h21, 8'h02, 8'h10, 8'hAB};
		flush_buf(1'b1);
		octet_buf = '{8'h00, 8'h55};
		flush_buf(1'b1);
		wait_drained();

		// Random streams are spread over the phases by a running octet target.
		start = total_queued;
		for (phase_no = 2; phase_no < LAST_PHASE; phase_no++) begin
			case (phase_no % 3)
				0: begin
					tx_max_gap = 0;
					rx_max_gap = 0;
				end
				1: begin
					tx_max_gap = 12;
					rx_max_gap = 12;
				end
				default: begin
					tx_max_gap = 3;
					rx_max_gap = 8;
				end
			endcase
			if (phase_no == PRESSURE_PHASE) begin
				tx_max_gap = 0;
				rx_max_gap = 1;
			end
			mode = (phase_no < 4) ? 1'(phase_no % 2) : 1'($urandom_range(1, 0));
			write_mode(mode);
			@(negedge clk);
			phase_start = total_queued;
			do
				build_stream(mode, 1'b1);
			while (total_queued - start < RANDOM_ITEMS * (phase_no - 1) / (LAST_PHASE - 2)
				|| (phase_no == PRESSURE_PHASE && total_queued - phase_start < PRESSURE_MIN));
			// Leave a stream open now and then so the next mode write lands
			// in the middle of a packet.
			if (phase_no % 4 == 3)
				build_stream(mode, 1'b0);
			wait_drained();
		end

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/pgp_pkg.sv
src/pgp_core.sv
src/pgp_packet_deframer.sv
tb/testbench.sv
